@@ hw/rtl/kmap_pkg.sv @@
package kmap_pkg;

  localparam int SLOT_COUNT_LOG2_DEF = 10;
  localparam int ENTRY_CAP_DEF       = 256;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [1:0] FUNC_FIND  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] MUL_LO_LO = 2'd0;
  localparam logic [1:0] MUL_HI_LO = 2'd1;
  localparam logic [1:0] MUL_LO_HI = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       mul_round;
    logic       mix;
    logic       slot_inc;
    logic       clr_wr;
    logic       clr_count;
    logic       fin_hit;
    logic       fin_miss;
    logic       fin_zero;
    logic       exhausted;
  } kmap_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       clr_last;
    logic       slot_valid;
    logic       key_match;
    logic       probe_last;
  } kmap_sts_t;

endpackage

@@ hw/rtl/key_to_index_hash_map.sv @@
// Key-to-index hash map with linear probing.
// Input channel in_*: in_tuser carries the function (find, get or add, clear),
// in_tdata the key and the tag of an entry to add. Each accepted item gives
// exactly one item on out_*, holding the entry index and the hit, added,
// no_entry and slot_dropped flags.
// A find or get-or-add is accepted, then hashed through one shared 32x32
// multiplier (three partial products per 64-bit multiply, two multiplies),
// then each probed slot passes a slot read, a slot check and a key check, in
// the order set by the registered slot read followed by the registered key
// read; the empty slot that ends a miss stops at the slot check. The result
// is held in the output register.
// A clear walks all 2^SLOT_COUNT_LOG2 slots, one slot per cycle, then
// answers. After reset the same pass runs before the first item is taken.
// One item is worked on at a time; a new item may be accepted while the last
// result still waits in the output register. If the receiver stalls, the
// block finishes its current item and holds it until the output register is
// free.
module key_to_index_hash_map
  import kmap_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SLOT_COUNT_LOG2_DEF,
  parameter int ENTRY_CAP       = ENTRY_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key[63:0], tag_value[71:64]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // index[7:0], hit, added, no_entry, slot_dropped, zeros
);

  kmap_cmd_t  cmd;
  kmap_sts_t  sts;
  logic [7:0] res_index;
  logic       res_hit;
  logic       res_added;
  logic       res_no_entry;
  logic       res_dropped;

  kmap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  kmap_dp #(
    .SLOT_COUNT_LOG2 (SLOT_COUNT_LOG2),
    .ENTRY_CAP       (ENTRY_CAP)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_tuser),
    .in_key       (in_tdata[63:0]),
    .in_tag       (in_tdata[71:64]),
    .cmd          (cmd),
    .sts          (sts),
    .res_index    (res_index),
    .res_hit      (res_hit),
    .res_added    (res_added),
    .res_no_entry (res_no_entry),
    .res_dropped  (res_dropped)
  );

  assign out_tdata = {4'b0000, res_dropped, res_no_entry, res_added, res_hit, res_index};

endmodule

@@ hw/rtl/kmap_ctrl.sv @@
module kmap_ctrl
  import kmap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output kmap_cmd_t cmd,
  input  kmap_sts_t sts
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_M0   = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_MX   = 4'd5;
  localparam logic [3:0] S_RS   = 4'd6;
  localparam logic [3:0] S_SC   = 4'd7;
  localparam logic [3:0] S_KC   = 4'd8;
  localparam logic [3:0] S_ZR   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       round_r, round_nxt;
  logic       reply_r, reply_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       fin_any;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_IDLE);
  assign fin_any    = cmd.fin_hit || cmd.fin_miss || cmd.fin_zero;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    reply_nxt = reply_r;
    cmd       = '0;
    cmd.mul_round = round_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr    = 1'b1;
        cmd.clr_count = 1'b1;
        if (sts.clr_last) begin
          state_nxt = reply_r ? S_ZR : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          round_nxt = 1'b0;
          if (sts.func == FUNC_CLEAR) begin
            reply_nxt = 1'b1;
            state_nxt = S_CLR;
          end else if (sts.func == FUNC_FIND || sts.func == FUNC_ADD) begin
            state_nxt = S_M0;
          end else begin
            state_nxt = S_ZR;
          end
        end
      end
      S_M0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LO_LO;
        state_nxt    = S_M1;
      end
      S_M1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_HI_LO;
        state_nxt    = S_M2;
      end
      S_M2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LO_HI;
        state_nxt    = S_MX;
      end
      S_MX: begin
        cmd.mix = 1'b1;
        if (round_r) begin
          state_nxt = S_RS;
        end else begin
          round_nxt = 1'b1;
          state_nxt = S_M0;
        end
      end
      S_RS: begin
        state_nxt = S_SC;
      end
      S_SC: begin
        if (sts.slot_valid) begin
          state_nxt = S_KC;
        end else if (out_free) begin
          cmd.fin_miss = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_KC: begin
        if (sts.key_match) begin
          if (out_free) begin
            cmd.fin_hit = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else if (sts.probe_last) begin
          if (out_free) begin
            cmd.fin_miss  = 1'b1;
            cmd.exhausted = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_RS;
        end
      end
      S_ZR: begin
        if (out_free) begin
          cmd.fin_zero = 1'b1;
          reply_nxt    = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_any) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      round_r     <= 1'b0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("input accepted during slot clearing");
  a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    fin_any |-> out_free)
    else $error("result finished while output register is occupied");
  a_fin_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.fin_hit, cmd.fin_miss, cmd.fin_zero}))
    else $error("more than one result source in one cycle");
`endif

endmodule

@@ hw/rtl/kmap_dp.sv @@
module kmap_dp
  import kmap_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SLOT_COUNT_LOG2_DEF,
  parameter int ENTRY_CAP       = ENTRY_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [7:0]  in_tag,
  input  kmap_cmd_t   cmd,
  output kmap_sts_t   sts,
  output logic [7:0]  res_index,
  output logic        res_hit,
  output logic        res_added,
  output logic        res_no_entry,
  output logic        res_dropped
);

  localparam int SW         = SLOT_COUNT_LOG2;
  localparam int SLOT_COUNT = 1 << SW;
  localparam int EW         = $clog2(ENTRY_CAP);
  localparam int CW         = $clog2(ENTRY_CAP + 1);

  logic [EW:0]   slot_mem [SLOT_COUNT];
  logic [63:0]   key_mem  [ENTRY_CAP];
  logic [7:0]    tag_mem  [ENTRY_CAP];

  logic [1:0]    func_r;
  logic [63:0]   key_r;
  logic [7:0]    tag_r;
  logic [63:0]   hv_r;
  logic [63:0]   acc_r;
  logic [SW-1:0] slot_r;
  logic [SW-1:0] probe_r;
  logic [SW-1:0] clr_addr_r;
  logic [CW-1:0] count_r;
  logic [EW:0]   slot_rd_r;
  logic [63:0]   key_rd_r;
  logic [7:0]    res_index_r;
  logic          res_hit_r;
  logic          res_added_r;
  logic          res_no_entry_r;
  logic          res_dropped_r;

  logic [63:0]   mul_b;
  logic [31:0]   ma, mb;
  logic [63:0]   prod;
  logic [63:0]   mix_v;
  logic          can_add;
  logic          do_add;
  logic [EW-1:0] new_idx;

  assign mul_b = cmd.mul_round ? MIX_C2 : MIX_C1;
  assign ma    = (cmd.mul_step == MUL_HI_LO) ? hv_r[63:32] : hv_r[31:0];
  assign mb    = (cmd.mul_step == MUL_LO_HI) ? mul_b[63:32] : mul_b[31:0];
  assign prod  = ma * mb;
  assign mix_v = acc_r ^ (acc_r >> MIX_SHIFT);

  assign can_add = (func_r == FUNC_ADD) && (count_r < CW'(ENTRY_CAP));
  assign do_add  = cmd.fin_miss && can_add;
  assign new_idx = count_r[EW-1:0];

  assign sts.func       = in_func;
  assign sts.clr_last   = (clr_addr_r == {SW{1'b1}});
  assign sts.slot_valid = slot_rd_r[EW];
  assign sts.key_match  = (key_rd_r == key_r);
  assign sts.probe_last = (probe_r == {SW{1'b1}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_key;
      tag_r  <= in_tag;
      hv_r   <= in_key ^ (in_key >> MIX_SHIFT);
    end else if (cmd.mix) begin
      hv_r <= mix_v;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_step == MUL_LO_LO) begin
        acc_r <= prod;
      end else begin
        acc_r <= acc_r + {prod[31:0], 32'h0};
      end
    end
    if (cmd.mix) begin
      slot_r  <= mix_v[SW-1:0];
      probe_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r  <= slot_r + 1'b1;
      probe_r <= probe_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (do_add) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      slot_mem[clr_addr_r] <= '0;
    end else if (do_add && !cmd.exhausted) begin
      slot_mem[slot_r] <= {1'b1, new_idx};
    end
    slot_rd_r <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      key_mem[new_idx] <= key_r;
      tag_mem[new_idx] <= tag_r;
    end
    key_rd_r <= key_mem[slot_rd_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_hit) begin
      res_index_r    <= 8'(slot_rd_r[EW-1:0]);
      res_hit_r      <= 1'b1;
      res_added_r    <= 1'b0;
      res_no_entry_r <= 1'b0;
      res_dropped_r  <= 1'b0;
    end else if (cmd.fin_miss) begin
      res_index_r    <= can_add ? 8'(new_idx) : 8'h0;
      res_hit_r      <= 1'b0;
      res_added_r    <= can_add;
      res_no_entry_r <= !can_add;
      res_dropped_r  <= can_add && cmd.exhausted;
    end else if (cmd.fin_zero) begin
      res_index_r    <= 8'h0;
      res_hit_r      <= 1'b0;
      res_added_r    <= 1'b0;
      res_no_entry_r <= 1'b0;
      res_dropped_r  <= 1'b0;
    end
  end

  assign res_index    = res_index_r;
  assign res_hit      = res_hit_r;
  assign res_added    = res_added_r;
  assign res_no_entry = res_no_entry_r;
  assign res_dropped  = res_dropped_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRY_CAP))
    else $error("entry count above capacity");
  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_hit |=> res_hit_r && !res_added_r && !res_no_entry_r)
    else $error("hit result has inconsistent flags");
  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_add && !cmd.clr_count) |=> count_r == $past(count_r) + 1'b1)
    else $error("allocation did not advance the entry count");
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_count |=> count_r == '0)
    else $error("clearing left a non-zero entry count");
`endif

endmodule

@@ test/key_to_index_hash_map_tb.sv @@
`timescale 1ns / 100ps

module key_to_index_hash_map_tb;
  import kmap_pkg::*;

  localparam int SLOTS = 1 << SLOT_COUNT_LOG2_DEF;
  localparam int IDLE_LIMIT = 8000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] index;
    logic       hit;
    logic       added;
    logic       no_entry;
    logic       dropped;
  } map_result_t;

  class map_scoreboard;
    bit          slot_used [SLOTS];
    int          slot_entry [SLOTS];
    logic [63:0] entry_key [ENTRY_CAP_DEF];
    int          entry_count;
    map_result_t pending [$];
    int          errors;

    function int home_slot(logic [63:0] k);
      logic [63:0] x;
      x = k ^ (k >> MIX_SHIFT);
      x = x * MIX_C1;
      x = x ^ (x >> MIX_SHIFT);
      x = x * MIX_C2;
      x = x ^ (x >> MIX_SHIFT);
      return int'(x[31:0] & (SLOTS - 1));
    endfunction

    function int find_entry(logic [63:0] k);
      int h;
      int s;
      h = home_slot(k);
      for (int p = 0; p < SLOTS; p++) begin
        s = (h + p) % SLOTS;
        if (!slot_used[s]) return -1;
        if (entry_key[slot_entry[s]] == k) return slot_entry[s];
      end
      return -1;
    endfunction

    function bit place_entry(logic [63:0] k, int e);
      int h;
      int s;
      h = home_slot(k);
      for (int p = 0; p < SLOTS; p++) begin
        s = (h + p) % SLOTS;
        if (!slot_used[s]) begin
          slot_used[s] = 1;
          slot_entry[s] = e;
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_item(logic [1:0] func, logic [63:0] k, logic [7:0] tag);
      map_result_t r;
      int e;
      r = '0;
      if (func == FUNC_FIND || func == FUNC_ADD) begin
        e = find_entry(k);
        if (e >= 0) begin
          r.index = e[7:0];
          r.hit = 1;
        end else if (func == FUNC_FIND || entry_count >= ENTRY_CAP_DEF) begin
          r.no_entry = 1;
        end else begin
          e = entry_count;
          entry_count++;
          entry_key[e] = k;
          r.dropped = !place_entry(k, e);
          r.index = e[7:0];
          r.added = 1;
        end
      end else if (func == FUNC_CLEAR) begin
        foreach (slot_used[i]) slot_used[i] = 0;
        entry_count = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] data);
      map_result_t got;
      map_result_t exp;
      got.index = data[7:0];
      got.hit = data[8];
      got.added = data[9];
      got.no_entry = data[10];
      got.dropped = data[11];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.index !== exp.index) begin
        $display("%0t: index expected %0d actual %0d", $time, exp.index, got.index);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp.hit, got.hit);
        errors++;
      end
      if (got.added !== exp.added) begin
        $display("%0t: added expected %b actual %b", $time, exp.added, got.added);
        errors++;
      end
      if (got.no_entry !== exp.no_entry) begin
        $display("%0t: no_entry expected %b actual %b", $time, exp.no_entry, got.no_entry);
        errors++;
      end
      if (got.dropped !== exp.dropped) begin
        $display("%0t: slot_dropped expected %b actual %b", $time, exp.dropped, got.dropped);
        errors++;
      end
      if (data[15:12] !== 4'd0) begin
        $display("%0t: padding expected 0 actual %h", $time, data[15:12]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;

  map_scoreboard sb;
  logic [63:0]   key_pool [$];
  int            idle_cycles = 0;
  bit            steady = 0;

  key_to_index_hash_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [63:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(logic [1:0] func, logic [63:0] k, logic [7:0] tag);
    int gap;
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = func;
    in_tdata = {tag, k};
    do @(posedge clk); while (!in_tready);
    sb.note_item(func, k, tag);
    if (func == FUNC_ADD) key_pool.push_back(k);
    if (func == FUNC_CLEAR) key_pool.delete();
    gap = gap_length();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count, int clear_pct);
    int r;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 999);
      if (key_pool.size() != 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else k = random_key();
      if (r < clear_pct * 10) send_item(FUNC_CLEAR, random_key(), 8'($urandom()));
      else if (r < clear_pct * 10 + 10) send_item(FUNC_UNUSED, random_key(), 8'($urandom()));
      else if (r < 550) send_item(FUNC_ADD, random_key(), 8'($urandom()));
      else if (r < 750) send_item(FUNC_ADD, k, 8'($urandom()));
      else if (r < 930) send_item(FUNC_FIND, k, 8'($urandom()));
      else send_item(FUNC_FIND, random_key(), 8'($urandom()));
    end
  endtask

  always begin
    @(negedge clk);
    if (steady || $urandom_range(0, 99) < 60) begin
      out_tready = 1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end else begin
      out_tready = 0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 50)) @(negedge clk);
      else repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_item(FUNC_FIND, 64'd0, 8'h00);
    send_item(FUNC_ADD, 64'd0, 8'h00);
    send_item(FUNC_ADD, '1, 8'hff);
    send_item(FUNC_ADD, 64'h8000_0000_0000_0000, 8'h5a);
    send_item(FUNC_FIND, '1, 8'h00);
    send_item(FUNC_FIND, 64'd0, 8'hff);
    send_item(FUNC_ADD, 64'h8000_0000_0000_0000, 8'ha5);
    send_item(FUNC_FIND, 64'h0000_0000_0000_0001, 8'h00);
    send_item(FUNC_UNUSED, '1, 8'hff);
    send_item(FUNC_FIND, '1, 8'h00);
    send_item(FUNC_CLEAR, '1, 8'hff);
    send_item(FUNC_FIND, 64'd0, 8'h00);
    send_item(FUNC_ADD, '1, 8'h3c);
    send_item(FUNC_FIND, '1, 8'h00);

    drain_results();
    steady = 1;
    random_phase(60, 0);
    steady = 0;
    drain_results();

    // Heavy adding without clears fills the entry store and exercises the full case.
    random_phase(420, 0);
    send_item(FUNC_CLEAR, 64'd0, 8'h00);
    random_phase(330, 3);
    send_item(FUNC_CLEAR, 64'd0, 8'h00);
    random_phase(420, 0);
    send_item(FUNC_FIND, '1, 8'h00);

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ key_to_index_hash_map.f @@
hw/rtl/kmap_pkg.sv
hw/rtl/kmap_ctrl.sv
hw/rtl/kmap_dp.sv
hw/rtl/key_to_index_hash_map.sv
test/key_to_index_hash_map_tb.sv
